[src/voxel_heat_source_deposit_macros.svh]
// assertion helpers for the heat source deposit block
`ifndef VOXEL_HEAT_SOURCE_DEPOSIT_MACROS_SVH
`define VOXEL_HEAT_SOURCE_DEPOSIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define VHSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define VHSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/vhsd_pkg.sv]
package vhsd_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int EXP_ENTRIES_DEF = 64;

	localparam logic [1:0] MODE_OFF     = 2'd0;
	localparam logic [1:0] MODE_UNIFORM = 2'd1;
	localparam logic [1:0] MODE_GAUSS   = 2'd2;
	localparam logic [1:0] MODE_PHASE   = 2'd3;

	localparam logic [2:0] CFG_KERNEL_MODE = 3'd0;
	localparam logic [2:0] CFG_SOURCE_VAL  = 3'd1;
	localparam logic [2:0] CFG_CENTER_X    = 3'd2;
	localparam logic [2:0] CFG_CENTER_Y    = 3'd3;
	localparam logic [2:0] CFG_CENTER_Z    = 3'd4;
	localparam logic [2:0] CFG_INV_RSQ_X   = 3'd5;
	localparam logic [2:0] CFG_INV_RSQ_Y   = 3'd6;
	localparam logic [2:0] CFG_INV_RSQ_Z   = 3'd7;

	localparam logic [17:0] TERM_CAP = 18'h20000;
	localparam logic [16:0] ONE_Q16  = 17'h10000;

	// shift-subtract quotient, only evaluated while building constants
	function automatic logic [63:0] div_small(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-x) in Q16 from x in Q32: taylor series of exp(-x/16) in Q30,
	// then squared four times, rounded half up
	function automatic logic [16:0] exp_entry(input logic [63:0] x32);
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] e;
		logic [63:0] rnd;
		y = x32 >> 6;
		term = 64'd1 << 30;
		pos = 64'd1 << 30;
		neg = 64'd0;
		for (logic [63:0] n = 64'd1; n <= 64'd12; n++) begin
			term = div_small((term * y) >> 30, n);
			if (n[0]) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		e = (pos > neg) ? pos - neg : 64'd0;
		for (int r = 0; r < 4; r++) begin
			e = (e * e) >> 30;
		end
		rnd = (e + (64'd1 << 13)) >> 14;
		return rnd[16:0];
	endfunction

endpackage

[src/voxel_heat_source_deposit.sv]
// an accepted input reaches out_valid through the stage and output registers
// throughput: one voxel per cycle when out_stall is low; stall ripples back
// through the load chain within the cycle; empty stages fill while output waits
// reset: arst_n clears all valid bits and every configuration register to
// zero (mode off); the exp table is constant and needs no load
module voxel_heat_source_deposit #(
	parameter int COORD_BITS = vhsd_pkg::COORD_BITS_DEF,
	parameter int EXP_TABLE_ENTRIES = vhsd_pkg::EXP_ENTRIES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [31:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [COORD_BITS-1:0]   voxel_x,
	input  logic [COORD_BITS-1:0]   voxel_y,
	input  logic [COORD_BITS-1:0]   voxel_z,
	input  logic [16:0]             phase_fraction,
	input  logic signed [31:0]      qdot_in,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [31:0]      qdot_out,
	output logic                    in_region
);
	import vhsd_pkg::*;

	`include "voxel_heat_source_deposit_macros.svh"

	localparam int SW = ((COORD_BITS + 8) > 21 ? (COORD_BITS + 8) : 21) + 1;
	localparam int D2W = 2 * SW;
	localparam int IW = $clog2(EXP_TABLE_ENTRIES);
	localparam int PW = 16 + IW;

	// configuration registers
	logic [1:0]         kernel_mode_q;
	logic signed [31:0] source_value_q;
	logic signed [20:0] center_x_q, center_y_q, center_z_q;
	logic [23:0]        inv_rsq_x_q, inv_rsq_y_q, inv_rsq_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_mode_q <= MODE_OFF;
			source_value_q <= '0;
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			inv_rsq_x_q <= '0;
			inv_rsq_y_q <= '0;
			inv_rsq_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KERNEL_MODE: kernel_mode_q <= cfg_data[1:0];
				CFG_SOURCE_VAL:  source_value_q <= $signed(cfg_data);
				CFG_CENTER_X:    center_x_q <= $signed(cfg_data[20:0]);
				CFG_CENTER_Y:    center_y_q <= $signed(cfg_data[20:0]);
				CFG_CENTER_Z:    center_z_q <= $signed(cfg_data[20:0]);
				CFG_INV_RSQ_X:   inv_rsq_x_q <= cfg_data[23:0];
				CFG_INV_RSQ_Y:   inv_rsq_y_q <= cfg_data[23:0];
				CFG_INV_RSQ_Z:   inv_rsq_z_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// constant exp(-4.5*k/(N-1)) table
	logic [16:0] exp_rom [EXP_TABLE_ENTRIES];

	for (genvar k = 0; k < EXP_TABLE_ENTRIES; k++) begin : g_rom
		localparam logic [63:0] X32 =
			(64'd9 * 64'h8000_0000 * 64'(k)) / 64'(EXP_TABLE_ENTRIES - 1);
		localparam logic [16:0] ROM_VAL = exp_entry(X32);
		assign exp_rom[k] = ROM_VAL;
	end

	// stage load enables, each stage fills when empty or when it drains
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic out_valid_q;
	logic load_s1, load_s2, load_s3, load_s4, load_s5, load_s6, load_s7, load_out;

	assign load_out = !out_valid_q || !out_stall;
	assign load_s7 = !valid_s7 || load_out;
	assign load_s6 = !valid_s6 || load_s7;
	assign load_s5 = !valid_s5 || load_s6;
	assign load_s4 = !valid_s4 || load_s5;
	assign load_s3 = !valid_s3 || load_s4;
	assign load_s2 = !valid_s2 || load_s3;
	assign load_s1 = !valid_s1 || load_s2;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= in_valid;
			if (load_s2) valid_s2 <= valid_s1;
			if (load_s3) valid_s3 <= valid_s2;
			if (load_s4) valid_s4 <= valid_s3;
			if (load_s5) valid_s5 <= valid_s4;
			if (load_s6) valid_s6 <= valid_s5;
			if (load_s7) valid_s7 <= valid_s6;
			if (load_out) out_valid_q <= valid_s7;
		end
	end

	// per-axis views of the input and the configuration
	logic [COORD_BITS-1:0] vox_c [3];
	logic signed [20:0]    ctr_c [3];
	logic [23:0]           inv_c [3];

	always_comb begin
		vox_c[0] = voxel_x;
		vox_c[1] = voxel_y;
		vox_c[2] = voxel_z;
		ctr_c[0] = center_x_q;
		ctr_c[1] = center_y_q;
		ctr_c[2] = center_z_q;
		inv_c[0] = inv_rsq_x_q;
		inv_c[1] = inv_rsq_y_q;
		inv_c[2] = inv_rsq_z_q;
	end

	// stage 1: absolute distance in 1/256 voxel, fraction clamp
	logic signed [SW-1:0] diff_c [3];
	logic [SW-1:0]        dist_c [3];
	logic [16:0]          frac_c;
	logic [SW-1:0]        dist_s1 [3];
	logic [16:0]          frac_s1;
	logic signed [31:0]   q_s1;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			diff_c[a] = $signed({{(SW - COORD_BITS - 8){1'b0}}, vox_c[a], 8'd0})
				- $signed({{(SW - 21){ctr_c[a][20]}}, ctr_c[a]});
			dist_c[a] = diff_c[a][SW-1] ? SW'(-diff_c[a]) : SW'(diff_c[a]);
		end
		frac_c = (phase_fraction > ONE_Q16) ? ONE_Q16 : phase_fraction;
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			for (int a = 0; a < 3; a++) dist_s1[a] <= dist_c[a];
			frac_s1 <= frac_c;
			q_s1 <= qdot_in;
		end
	end

	// stage 2: squared distance
	logic [D2W-1:0]     d2_s2 [3];
	logic [16:0]        frac_s2;
	logic signed [31:0] q_s2;

	always_ff @(posedge clk) begin
		if (load_s2) begin
			for (int a = 0; a < 3; a++) d2_s2[a] <= dist_s1[a] * dist_s1[a];
			frac_s2 <= frac_s1;
			q_s2 <= q_s1;
		end
	end

	// stage 3: d2 * inv split into two partial products; from 2^40 up it caps
	logic [47:0]        plo_s3 [3];
	logic [39:0]        phi_s3 [3];
	logic               big_s3 [3];
	logic [16:0]        frac_s3;
	logic signed [31:0] q_s3;

	always_ff @(posedge clk) begin
		if (load_s3) begin
			for (int a = 0; a < 3; a++) begin
				plo_s3[a] <= d2_s2[a][23:0] * inv_c[a];
				phi_s3[a] <= d2_s2[a][39:24] * inv_c[a];
				big_s3[a] <= |d2_s2[a][D2W-1:40];
			end
			frac_s3 <= frac_s2;
			q_s3 <= q_s2;
		end
	end

	// stage 4: per-axis term in Q16, capped at 2.0
	logic [63:0]        full_c [3];
	logic [41:0]        tq_c [3];
	logic [17:0]        term_c [3];
	logic [17:0]        term_s4 [3];
	logic [16:0]        frac_s4;
	logic signed [31:0] q_s4;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			full_c[a] = {phi_s3[a], 24'd0} + {16'd0, plo_s3[a]};
			tq_c[a] = full_c[a][63:22];
			if (inv_c[a] == 24'd0) begin
				term_c[a] = '0;
			end else if (big_s3[a] || tq_c[a] > 42'(TERM_CAP)) begin
				term_c[a] = TERM_CAP;
			end else begin
				term_c[a] = tq_c[a][17:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s4) begin
			for (int a = 0; a < 3; a++) term_s4[a] <= term_c[a];
			frac_s4 <= frac_s3;
			q_s4 <= q_s3;
		end
	end

	// stage 5: normalized distance, hit test, table position
	logic [18:0]        s_c;
	logic [PW-1:0]      pos_c;
	logic               hit_c;
	logic               hit_s5;
	logic [IW-1:0]      idx_s5;
	logic [15:0]        pfrac_s5;
	logic [16:0]        frac_s5;
	logic signed [31:0] q_s5;

	always_comb begin
		s_c = {1'b0, term_s4[0]} + {1'b0, term_s4[1]} + {1'b0, term_s4[2]};
		pos_c = PW'(s_c[16:0]) * PW'(EXP_TABLE_ENTRIES - 1);
		if (kernel_mode_q inside {MODE_UNIFORM, MODE_GAUSS}) begin
			hit_c = (s_c <= 19'(ONE_Q16));
		end else if (kernel_mode_q == MODE_PHASE) begin
			hit_c = (frac_s4 != 17'd0);
		end else begin
			hit_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s5) begin
			hit_s5 <= hit_c;
			idx_s5 <= pos_c[PW-1:16];
			pfrac_s5 <= pos_c[15:0];
			frac_s5 <= frac_s4;
			q_s5 <= q_s4;
		end
	end

	// stage 6: interpolated exp weight and weight select
	localparam logic [IW-1:0] LAST_IDX = IW'(EXP_TABLE_ENTRIES - 1);

	logic               last_c;
	logic [IW-1:0]      idx_a_c, idx_b_c;
	logic [16:0]        rom_a_c, rom_b_c, rdiff_c, gauss_c, weight_c;
	logic [32:0]        iprod_c;
	logic [16:0]        weight_s6;
	logic               hit_s6;
	logic signed [31:0] q_s6;

	always_comb begin
		last_c = (idx_s5 >= LAST_IDX);
		idx_a_c = last_c ? LAST_IDX : idx_s5;
		idx_b_c = last_c ? LAST_IDX : idx_s5 + IW'(1);
		rom_a_c = exp_rom[idx_a_c];
		rom_b_c = exp_rom[idx_b_c];
		rdiff_c = (rom_a_c > rom_b_c) ? rom_a_c - rom_b_c : 17'd0;
		iprod_c = rdiff_c * pfrac_s5;
		gauss_c = last_c ? rom_a_c : rom_a_c - iprod_c[32:16];
		case (kernel_mode_q)
			MODE_UNIFORM: weight_c = ONE_Q16;
			MODE_GAUSS:   weight_c = gauss_c;
			MODE_PHASE:   weight_c = frac_s5;
			default:      weight_c = 17'd0;
		endcase
		if (!hit_s5) weight_c = 17'd0;
	end

	always_ff @(posedge clk) begin
		if (load_s6) begin
			weight_s6 <= weight_c;
			hit_s6 <= hit_s5;
			q_s6 <= q_s5;
		end
	end

	// stage 7: value times weight, rounded half up
	logic signed [49:0] sprod_c;
	logic signed [49:0] srnd_c;
	logic signed [33:0] add_s7;
	logic               hit_s7;
	logic signed [31:0] q_s7;

	always_comb begin
		sprod_c = $signed(source_value_q) * $signed({1'b0, weight_s6});
		srnd_c = sprod_c + 50'sd32768;
	end

	always_ff @(posedge clk) begin
		if (load_s7) begin
			add_s7 <= srnd_c[49:16];
			hit_s7 <= hit_s6;
			q_s7 <= q_s6;
		end
	end

	// output register: saturating accumulate
	logic signed [34:0] sum_c;
	logic signed [31:0] sat_c;
	logic signed [31:0] qdot_q;
	logic               in_region_q;

	always_comb begin
		sum_c = 35'(q_s7) + 35'(add_s7);
		if (sum_c > 35'sd2147483647) begin
			sat_c = 32'sh7FFF_FFFF;
		end else if (sum_c < -35'sd2147483648) begin
			sat_c = 32'sh8000_0000;
		end else begin
			sat_c = sum_c[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			qdot_q <= sat_c;
			in_region_q <= hit_s7;
		end
	end

	assign out_valid = out_valid_q;
	assign qdot_out = qdot_q;
	assign in_region = in_region_q;

	`VHSD_ASSERT_IMPL(a_stall_needs_full_out, clk, arst_n, in_stall, out_valid_q && out_stall, "input stalled while output transaction not blocked")
	`VHSD_ASSERT_NEXT(a_s7_moves_to_out, clk, arst_n, valid_s7 && load_out, out_valid_q, "item in last stage lost on its way to the output")
	`VHSD_ASSERT_IMPL(a_weight_range, clk, arst_n, valid_s6, weight_s6 <= ONE_Q16, "weight above one")

endmodule
